[hdl/slcfr_pkg.sv]
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types and constants for the sync/length/CRC16 frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;
  typedef logic [16:0] pos_t;
  typedef logic [1:0]  status_t;

  localparam byte_t SYNC_FIRST  = 8'hAA;
  localparam byte_t SYNC_SECOND = 8'h55;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;

  localparam pos_t FRAME_OVERHEAD = 17'd10;

  // byte positions within a frame
  localparam pos_t POS_HUNT    = 17'd0;
  localparam pos_t POS_SYNC2   = 17'd1;
  localparam pos_t POS_VERSION = 17'd2;
  localparam pos_t POS_TYPE    = 17'd3;
  localparam pos_t POS_SEQ_LO  = 17'd4;
  localparam pos_t POS_SEQ_HI  = 17'd5;
  localparam pos_t POS_LEN_LO  = 17'd6;
  localparam pos_t POS_LEN_HI  = 17'd7;
  localparam pos_t POS_PAYLOAD = 17'd8;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_BAD_VER = 2'd1;
  localparam status_t STATUS_BAD_CRC = 2'd2;

  localparam logic CFG_EXPECTED_VERSION = 1'b0;
  localparam logic CFG_MAX_FRAME_BYTES  = 1'b1;

endpackage

[hdl/slcfr_crc.sv]
// ----------------------------------------------------------------------------
// slcfr_crc
// CRC16-Modbus update by one byte, reflected polynomial, eight unrolled steps.
// ----------------------------------------------------------------------------
module slcfr_crc
  import slcfr_pkg::*;
(
  input  crc_t  crc_in,
  input  byte_t data_in,
  output crc_t  crc_out
);

  always_comb begin
    crc_t c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[hdl/sync_length_crc16_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Hunts for 0xAA 0x55, parses header, forwards payload bytes and reports
// frame end with version/CRC status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | rx_byte
//  out_    | output    | out_valid / out_stall| kind, byte, offset, type, seq,
//          |           |                      | length, status
//  cfg_    | input     | cfg_valid / cfg_ready| index, data
//
// One byte per cycle unless a held result stalls; input and result registers.
// Frame state updates as a byte moves from the input register to the result
// register; that move waits only while a held result is stalled.
// rst_n is synchronous; it returns the parser to the sync hunt and loads the
// register defaults (version 1, max frame 256 bytes).
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_receiver
  import slcfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_rx_byte,

  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_result_kind,
  output logic [7:0]   out_payload_byte,
  output logic [15:0]  out_payload_offset,
  output logic [7:0]   out_frame_type,
  output logic [15:0]  out_sequence_number,
  output logic [15:0]  out_length_field,
  output logic [1:0]   out_frame_status,

  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_data
);

  byte_t   exp_ver_r;
  pos_t    max_bytes_r;

  logic    v1_r;
  byte_t   b1_r;

  pos_t    pos_r, pos_nxt;
  crc_t    crc_r, crc_nxt;
  byte_t   ver_r, ver_nxt;
  byte_t   type_r, type_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  byte_t   crc_lo_r, crc_lo_nxt;

  logic    ov_r;
  logic    kind_r;
  byte_t   pbyte_r;
  logic [15:0] offs_r;
  status_t status_r;

  logic    out_free;
  logic    s1_go;
  logic    in_acc;
  logic    emit;
  logic    emit_kind;
  logic [15:0] emit_offs;
  status_t emit_status;

  crc_t    crc_seed;
  crc_t    crc_upd;
  pos_t    pos_inc;
  pos_t    crc_lo_pos;
  pos_t    frame_len;
  logic [15:0] len_full;
  logic [15:0] rx_crc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r   <= 8'd1;
      max_bytes_r <= 17'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXPECTED_VERSION: exp_ver_r   <= cfg_data[7:0];
        CFG_MAX_FRAME_BYTES:  max_bytes_r <= cfg_data;
      endcase
    end
  end

  assign out_free = !ov_r || !out_stall;
  assign s1_go    = v1_r && out_free;
  assign in_stall = v1_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (s1_go) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b1_r <= in_rx_byte;
    end
  end

  assign crc_seed   = (pos_r == POS_VERSION) ? CRC_INIT : crc_r;
  assign pos_inc    = pos_r + 17'd1;
  assign crc_lo_pos = {1'b0, len_r} + POS_PAYLOAD;
  assign len_full   = {b1_r, len_r[7:0]};
  assign frame_len  = {1'b0, len_full} + FRAME_OVERHEAD;
  assign rx_crc     = {b1_r, crc_lo_r};

  slcfr_crc u_crc (
    .crc_in  (crc_seed),
    .data_in (b1_r),
    .crc_out (crc_upd)
  );

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    ver_nxt     = ver_r;
    type_nxt    = type_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    crc_lo_nxt  = crc_lo_r;
    emit        = 1'b0;
    emit_kind   = KIND_PAYLOAD;
    emit_offs   = 16'd0;
    emit_status = STATUS_OK;
    priority if (pos_r == POS_HUNT) begin
      if (b1_r == SYNC_FIRST) begin
        pos_nxt = POS_SYNC2;
      end
    end else if (pos_r == POS_SYNC2) begin
      if (b1_r == SYNC_SECOND) begin
        pos_nxt = POS_VERSION;
      end else if (b1_r != SYNC_FIRST) begin
        pos_nxt = POS_HUNT;
      end
    end else if (pos_r < POS_PAYLOAD) begin
      crc_nxt = crc_upd;
      pos_nxt = pos_inc;
      unique case (pos_r[2:0])
        POS_VERSION[2:0]: ver_nxt  = b1_r;
        POS_TYPE[2:0]:    type_nxt = b1_r;
        POS_SEQ_LO[2:0]:  seq_nxt  = {8'h00, b1_r};
        POS_SEQ_HI[2:0]:  seq_nxt  = {b1_r, seq_r[7:0]};
        POS_LEN_LO[2:0]:  len_nxt  = {8'h00, b1_r};
        default: begin
          len_nxt = len_full;
          if (frame_len > max_bytes_r) begin
            pos_nxt = POS_HUNT;
          end
        end
      endcase
    end else if (pos_r < crc_lo_pos) begin
      crc_nxt   = crc_upd;
      pos_nxt   = pos_inc;
      emit      = 1'b1;
      emit_kind = KIND_PAYLOAD;
      emit_offs = pos_r[15:0] - POS_PAYLOAD[15:0];
    end else if (pos_r == crc_lo_pos) begin
      crc_lo_nxt = b1_r;
      pos_nxt    = pos_inc;
    end else begin
      emit      = 1'b1;
      emit_kind = KIND_END;
      pos_nxt   = POS_HUNT;
      priority if (ver_r != exp_ver_r) begin
        emit_status = STATUS_BAD_VER;
      end else if (rx_crc != crc_r) begin
        emit_status = STATUS_BAD_CRC;
      end else begin
        emit_status = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HUNT;
      crc_r    <= CRC_INIT;
      ver_r    <= 8'd0;
      type_r   <= 8'd0;
      seq_r    <= 16'd0;
      len_r    <= 16'd0;
      crc_lo_r <= 8'd0;
    end else if (s1_go) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      ver_r    <= ver_nxt;
      type_r   <= type_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_free) begin
      ov_r <= s1_go && emit;
    end
  end

  // result beat payload; type/seq/len come from the header registers as they
  // stand while the byte is processed
  logic [7:0]  otype_r;
  logic [15:0] oseq_r;
  logic [15:0] olen_r;

  always_ff @(posedge clk) begin
    if (out_free && s1_go && emit) begin
      kind_r   <= emit_kind;
      pbyte_r  <= (emit_kind == KIND_PAYLOAD) ? b1_r : 8'h00;
      offs_r   <= emit_offs;
      otype_r  <= type_r;
      oseq_r   <= seq_r;
      olen_r   <= len_r;
      status_r <= emit_status;
    end
  end

  assign out_valid           = ov_r;
  assign out_result_kind     = kind_r;
  assign out_payload_byte    = pbyte_r;
  assign out_payload_offset  = offs_r;
  assign out_frame_type      = otype_r;
  assign out_sequence_number = oseq_r;
  assign out_length_field    = olen_r;
  assign out_frame_status    = status_r;

endmodule

[test/sync_length_crc16_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver_tb
// Feeds byte streams of sync pairs, headers, payloads and CRC16 trailers into
// the frame receiver and checks every forwarded payload beat and frame-end
// beat against a cycle-free shadow of the parser, under random back-pressure
// and several register settings.
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_receiver_tb;
  import slcfr_pkg::*;

  typedef struct {
    logic          kind;
    logic [7:0]    pbyte;
    logic [15:0]   offs;
    logic [7:0]    ftype;
    logic [15:0]   seq;
    logic [15:0]   plen;
    logic [1:0]    status;
  } frame_beat_t;

  typedef enum {
    FRAME_WHOLE, FRAME_BAD_CRC, FRAME_HEADER_ONLY, FRAME_CUT, FRAME_SPLIT
  } frame_shape_t;

  class deframer_shadow;
    bit [7:0]    exp_version;
    bit [16:0]   max_bytes;
    bit [16:0]   pos;
    bit [16:0]   total_len;
    bit [15:0]   crc;
    bit [7:0]    ver;
    bit [7:0]    ftype;
    bit [15:0]   seq;
    bit [15:0]   plen;
    bit [7:0]    crc_lo;
    frame_beat_t expected_beats[$];
    int          errors;

    function new();
      exp_version = 8'd1;
      max_bytes   = 17'd256;
      pos         = POS_HUNT;
      total_len   = '0;
      crc         = CRC_INIT;
      ver         = '0;
      ftype       = '0;
      seq         = '0;
      plen        = '0;
      crc_lo      = '0;
      errors      = 0;
    endfunction

    static function crc_t crc16_byte(crc_t c, byte_t b);
      c ^= {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void set_reg(logic idx, logic [16:0] data);
      if (idx == CFG_EXPECTED_VERSION) exp_version = data[7:0];
      else max_bytes = data;
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction

    // advance the shadow parser by one accepted input beat
    function void take_byte(byte_t b);
      frame_beat_t r;
      if (pos == POS_HUNT) begin
        if (b == SYNC_FIRST) pos = POS_SYNC2;
        return;
      end
      if (pos == POS_SYNC2) begin
        if (b == SYNC_SECOND) pos = POS_VERSION;
        else if (b != SYNC_FIRST) pos = POS_HUNT;
        return;
      end
      if (pos < POS_PAYLOAD) begin
        if (pos == POS_VERSION) crc = CRC_INIT;
        crc = crc16_byte(crc, b);
        case (pos)
          POS_VERSION: ver = b;
          POS_TYPE:    ftype = b;
          POS_SEQ_LO:  seq = {8'h00, b};
          POS_SEQ_HI:  seq[15:8] = b;
          POS_LEN_LO:  plen = {8'h00, b};
          default:     plen[15:8] = b;
        endcase
        if (pos == POS_LEN_HI) begin
          total_len = {1'b0, plen} + FRAME_OVERHEAD;
          if (total_len > max_bytes) begin
            pos = POS_HUNT;
            total_len = '0;
            return;
          end
        end
        pos++;
        return;
      end
      r.ftype = ftype;
      r.seq   = seq;
      r.plen  = plen;
      if (pos < POS_PAYLOAD + {1'b0, plen}) begin
        crc = crc16_byte(crc, b);
        r.kind   = KIND_PAYLOAD;
        r.pbyte  = b;
        r.offs   = 16'(pos - POS_PAYLOAD);
        r.status = STATUS_OK;
        pos++;
        expected_beats.push_back(r);
        return;
      end
      if (pos == POS_PAYLOAD + {1'b0, plen}) begin
        crc_lo = b;
        pos++;
        return;
      end
      r.kind  = KIND_END;
      r.pbyte = '0;
      r.offs  = '0;
      // version fault outranks CRC fault
      if (ver != exp_version) r.status = STATUS_BAD_VER;
      else if ({b, crc_lo} != crc) r.status = STATUS_BAD_CRC;
      else r.status = STATUS_OK;
      pos = POS_HUNT;
      total_len = '0;
      expected_beats.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void match_beat(frame_beat_t got);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: kind %0h byte %0h", got.kind, got.pbyte);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("result_kind", 16'(want.kind), 16'(got.kind));
      compare_field("payload_byte", 16'(want.pbyte), 16'(got.pbyte));
      compare_field("payload_offset", want.offs, got.offs);
      compare_field("frame_type", 16'(want.ftype), 16'(got.ftype));
      compare_field("sequence_number", want.seq, got.seq);
      compare_field("length_field", want.plen, got.plen);
      compare_field("frame_status", 16'(want.status), 16'(got.status));
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [7:0]   in_rx_byte = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic         out_result_kind;
  logic [7:0]   out_payload_byte;
  logic [15:0]  out_payload_offset;
  logic [7:0]   out_frame_type;
  logic [15:0]  out_sequence_number;
  logic [15:0]  out_length_field;
  logic [1:0]   out_frame_status;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = CFG_EXPECTED_VERSION;
  logic [16:0]  cfg_data = '0;

  deframer_shadow shadow = new();
  frame_beat_t    seen;
  int unsigned    cycle_count = 0;
  int unsigned    items_sent = 0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  bit             hold_request = 1'b0;
  bit             hold_done = 1'b0;
  int unsigned    hold_left = 0;
  byte_t          cur_ver = 8'd1;
  int unsigned    cur_max = 256;

  sync_length_crc16_frame_receiver dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sync_length_crc16_frame_receiver_tb: FAIL");
      $finish;
    end
  end

  // result side back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind   = out_result_kind;
      seen.pbyte  = out_payload_byte;
      seen.offs   = out_payload_offset;
      seen.ftype  = out_frame_type;
      seen.seq    = out_sequence_number;
      seen.plen   = out_length_field;
      seen.status = out_frame_status;
      shadow.match_beat(seen);
    end
  end

  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    shadow.take_byte(b);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input byte_t ver, input int unsigned maxb);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_EXPECTED_VERSION;
    cfg_data  <= {9'd0, ver};
    do @(posedge clk); while (!cfg_ready);
    shadow.set_reg(CFG_EXPECTED_VERSION, {9'd0, ver});
    cfg_index <= CFG_MAX_FRAME_BYTES;
    cfg_data  <= maxb[16:0];
    do @(posedge clk); while (!cfg_ready);
    shadow.set_reg(CFG_MAX_FRAME_BYTES, maxb[16:0]);
    cfg_valid <= 1'b0;
    cur_ver = ver;
    cur_max = maxb;
  endtask

  task automatic send_frame(input byte_t ver, input byte_t ftype, input logic [15:0] seq,
                            input int unsigned len, input frame_shape_t shape,
                            input int unsigned extra_aa);
    byte_t       fb[$];
    crc_t        c;
    int unsigned n_send;
    fb = {ver, ftype, seq[7:0], seq[15:8], len[7:0], len[15:8]};
    repeat (len) fb.push_back(byte_t'($urandom));
    c = CRC_INIT;
    foreach (fb[i]) c = deframer_shadow::crc16_byte(c, fb[i]);
    if (shape == FRAME_BAD_CRC) c ^= crc_t'($urandom_range(16'hFFFF, 1));
    case (shape)
      FRAME_HEADER_ONLY: n_send = 6;
      FRAME_CUT:         n_send = $urandom_range(fb.size() - 1, 0);
      default:           n_send = fb.size();
    endcase
    send_byte(SYNC_FIRST);
    repeat (extra_aa) send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 0; i < n_send; i++) send_byte(fb[i]);
    if (shape == FRAME_HEADER_ONLY || shape == FRAME_CUT) return;
    // version register rewritten between payload and trailer
    if (shape == FRAME_SPLIT) begin
      settle();
      write_regs(ver, cur_max);
    end
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned stop_at, pick, len, cap, room, extra;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      room = (cur_max > 10) ? cur_max - 10 : 0;
      if (room > 65535) room = 65535;
      cap = (room < 12) ? room : 12;
      if ($urandom_range(9) == 0) cap = (room < 60) ? room : 60;
      len = $urandom_range(cap, 0);
      extra = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : 0;
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(cur_ver, byte_t'($urandom), 16'($urandom), len, FRAME_WHOLE, extra);
      end else if (pick < 65) begin
        send_frame(cur_ver ^ byte_t'(1 << $urandom_range(7)), byte_t'($urandom),
                   16'($urandom), len, FRAME_WHOLE, extra);
      end else if (pick < 75) begin
        send_frame(cur_ver, byte_t'($urandom), 16'($urandom), len, FRAME_BAD_CRC, extra);
      end else if (pick < 80) begin
        send_frame(~cur_ver, byte_t'($urandom), 16'($urandom), len, FRAME_BAD_CRC, extra);
      end else if (pick < 87) begin
        if (room < 65535)
          send_frame(cur_ver, byte_t'($urandom), 16'($urandom),
                     $urandom_range(1) ? room + 1 : $urandom_range(65535, room + 1),
                     FRAME_HEADER_ONLY, extra);
        else
          send_frame(cur_ver, byte_t'($urandom), 16'($urandom), len, FRAME_WHOLE, extra);
      end else if (pick < 93) begin
        send_frame(cur_ver, byte_t'($urandom), 16'($urandom), len, FRAME_CUT, extra);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          case ($urandom_range(3))
            0:       send_byte(SYNC_FIRST);
            1:       send_byte(SYNC_SECOND);
            default: send_byte(byte_t'($urandom));
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 22;
    rx_idle_pct = 63;
    send_frame(8'd1, 8'hFF, 16'hFFFF, 0, FRAME_WHOLE, 0);
    send_frame(8'd1, 8'h00, 16'h0000, 1, FRAME_WHOLE, 2);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_SECOND);
    send_frame(8'd2, 8'h5A, 16'h1234, 2, FRAME_WHOLE, 0);
    send_frame(8'd1, 8'hA5, 16'h8001, 1, FRAME_BAD_CRC, 0);
    send_frame(8'hFE, 8'h3C, 16'h7FFE, 0, FRAME_BAD_CRC, 0);
    send_frame(8'd1, 8'h11, 16'h2222, 65535, FRAME_HEADER_ONLY, 0);
    send_frame(8'd1, 8'h33, 16'h4444, 247, FRAME_HEADER_ONLY, 0);
    settle();
    write_regs(8'hFF, 10);
    send_frame(8'hFF, 8'h01, 16'h0102, 0, FRAME_WHOLE, 0);
    send_frame(8'hFF, 8'h02, 16'h0304, 1, FRAME_HEADER_ONLY, 0);
    send_frame(8'h77, 8'h03, 16'h0506, 0, FRAME_SPLIT, 1);
    settle();
    write_regs(8'h3C, 64);
    random_traffic(130);

    settle();
    tx_idle_pct = 63;
    rx_idle_pct = 22;
    write_regs(8'h00, 300);
    random_traffic(130);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_regs(8'hC3, 65545);
    hold_request = 1'b1;
    send_frame(cur_ver, byte_t'($urandom), 16'($urandom), 48, FRAME_WHOLE, 0);
    random_traffic(120);
    send_frame(cur_ver, byte_t'($urandom), 16'($urandom), 65535, FRAME_HEADER_ONLY, 0);
    settle();

    if (shadow.errors == 0 && shadow.outstanding() == 0)
      $display("sync_length_crc16_frame_receiver_tb: PASS");
    else
      $display("sync_length_crc16_frame_receiver_tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
hdl/slcfr_pkg.sv
hdl/slcfr_crc.sv
hdl/sync_length_crc16_frame_receiver.sv
test/sync_length_crc16_frame_receiver_tb.sv
